@@ rtl/core/mtc_qf_pkg.sv @@
// ----------------------------------------------------------------------------
// mtc_qf_pkg
// Shared types and constants of the quarter-frame time code generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mtc_qf_pkg;

    // Message bytes and tags
    localparam logic [7:0] QF_STATUS      = 8'hF1;
    localparam logic [7:0] HOURS_HIGH_TAG = 8'h70;
    localparam logic [3:0] RATE_CODE_25   = 4'h2;
    localparam logic [3:0] RATE_CODE_30   = 4'h6;

    // Wrap limits of the time units
    localparam logic [5:0] FRAMES_25_WRAP = 6'd25;
    localparam logic [5:0] FRAMES_30_WRAP = 6'd30;
    localparam logic [6:0] SECONDS_WRAP   = 7'd60;
    localparam logic [6:0] MINUTES_WRAP   = 7'd60;
    localparam logic [5:0] HOURS_WRAP     = 6'd24;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 8;

    // Piece numbers of the quarter-frame sequence
    localparam logic [1:0] PIECE_FRAMES  = 2'd0;
    localparam logic [1:0] PIECE_SECONDS = 2'd1;
    localparam logic [1:0] PIECE_MINUTES = 2'd2;
    localparam logic [1:0] PIECE_HOURS   = 2'd3;

    // Beats of a four-byte message
    localparam logic [1:0] BEAT_STATUS_LO = 2'd0;
    localparam logic [1:0] BEAT_LO        = 2'd1;
    localparam logic [1:0] BEAT_STATUS_HI = 2'd2;
    localparam logic [1:0] BEAT_HI        = 2'd3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RATE_THIRTY   = 3'd0,
        REG_OUTPUT_ENABLE = 3'd1,
        REG_START_HOURS   = 3'd2,
        REG_START_MINUTES = 3'd3,
        REG_START_SECONDS = 3'd4,
        REG_START_FRAMES  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [4:0] frames;
    } tc_time_t;

    typedef struct packed {
        logic load;   // reload time from the start registers
        logic tick;   // one field tick is consumed
        logic count;  // the tick runs the generator
    } tc_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/mtc_qf_timecode.sv @@
// ----------------------------------------------------------------------------
// mtc_qf_timecode
// Field flag, piece counter and hours:minutes:seconds:frames counter, with the
// values they take after a counting tick.
// ----------------------------------------------------------------------------
`default_nettype none

module mtc_qf_timecode (
    input  wire                    clk,
    input  wire                    rst_n,
    input  mtc_qf_pkg::tc_ctrl_t   ctrl,
    input  mtc_qf_pkg::tc_time_t   start,
    input  wire                    rate_thirty,
    output mtc_qf_pkg::tc_time_t   step_time,
    output logic [1:0]             step_piece
);

    mtc_qf_pkg::tc_time_t time_reg;
    mtc_qf_pkg::tc_time_t adv_time;
    logic [1:0]           piece_reg;
    logic                 field_reg;

    logic [5:0] frames_inc;
    logic [6:0] seconds_inc;
    logic [6:0] minutes_inc;
    logic [5:0] hours_inc;
    logic [5:0] frames_wrap;

    always_comb
    begin
        frames_inc  = {1'b0, time_reg.frames} + 6'd1;
        seconds_inc = {1'b0, time_reg.seconds} + 7'd1;
        minutes_inc = {1'b0, time_reg.minutes} + 7'd1;
        hours_inc   = {1'b0, time_reg.hours} + 6'd1;
        frames_wrap = rate_thirty ? mtc_qf_pkg::FRAMES_30_WRAP : mtc_qf_pkg::FRAMES_25_WRAP;

        adv_time = time_reg;
        // carry ripples upwards; compare at or above the limit so stray values wrap too
        if (frames_inc >= frames_wrap)
        begin
            adv_time.frames = 5'd0;
            if (seconds_inc >= mtc_qf_pkg::SECONDS_WRAP)
            begin
                adv_time.seconds = 6'd0;
                if (minutes_inc >= mtc_qf_pkg::MINUTES_WRAP)
                begin
                    adv_time.minutes = 6'd0;
                    adv_time.hours   = (hours_inc >= mtc_qf_pkg::HOURS_WRAP) ?
                                       5'd0 : hours_inc[4:0];
                end
                else
                begin
                    adv_time.minutes = minutes_inc[5:0];
                end
            end
            else
            begin
                adv_time.seconds = seconds_inc[5:0];
            end
        end
        else
        begin
            adv_time.frames = frames_inc[4:0];
        end

        // the frame advances on ticks that leave the field flag clear
        step_time  = field_reg ? adv_time : time_reg;
        step_piece = piece_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg  <= '0;
            piece_reg <= 2'd0;
            field_reg <= 1'b1;
        end
        else if (ctrl.load)
        begin
            time_reg  <= start;
            piece_reg <= 2'd0;
            field_reg <= 1'b1;
        end
        else if (ctrl.tick)
        begin
            field_reg <= ~field_reg;
            if (ctrl.count)
            begin
                time_reg  <= step_time;
                piece_reg <= step_piece;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/midi_timecode_quarter_frame_gen.sv @@
// ----------------------------------------------------------------------------
// midi_timecode_quarter_frame_gen
// Quarter-frame time code generator driven by video field ticks.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | count_enable
//  out     | out_valid/ out_ready | out_byte, byte_valid, last_of_tick, time_*
//  cfg     | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
//  A tick is held in the input register, then its results leave the message
//  register one per cycle while out_ready is high: four bytes for a tick with
//  output on, one status result with output off, none for an idle tick. The
//  message register paces counting ticks: one waits in the input register
//  until the last result of the one before it leaves, and can be taken as that
//  result leaves; idle ticks pass every cycle unless held behind a waiting one.
//  Reset clears the configuration, the time and the piece counter and sets the
//  field flag. A stalled output holds the message; the input register still
//  takes ticks until a counting tick waits in it. cfg_ready is always high.
//
`default_nettype none

module midi_timecode_quarter_frame_gen (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   in_valid,
    output logic                                  in_ready,
    input  wire                                   count_enable,
    output logic                                  out_valid,
    input  wire                                   out_ready,
    output logic [7:0]                            out_byte,
    output logic                                  byte_valid,
    output logic                                  last_of_tick,
    output logic [4:0]                            time_hours,
    output logic [5:0]                            time_minutes,
    output logic [5:0]                            time_seconds,
    output logic [4:0]                            time_frames,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [mtc_qf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire  [mtc_qf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // configuration
    logic                   rate_thirty_reg;
    logic                   output_enable_reg;
    mtc_qf_pkg::tc_time_t   start_reg;
    mtc_qf_pkg::tc_time_t   start_next;
    mtc_qf_pkg::cfg_reg_t   cfg_sel;
    logic                   start_write;

    // input register
    logic                   item_valid_reg;
    logic                   item_count_reg;
    logic                   item_take;

    // message register
    logic                   msg_valid_reg;
    logic                   msg_bytes_reg;
    logic [1:0]             beat_reg;
    logic [7:0]             lo_reg;
    logic [7:0]             hi_reg;
    mtc_qf_pkg::tc_time_t   msg_time_reg;
    logic                   msg_free;
    logic                   out_fire;

    mtc_qf_pkg::tc_ctrl_t   tc_ctrl;
    mtc_qf_pkg::tc_time_t   step_time;
    logic [1:0]             step_piece;
    logic [5:0]             unit_val;
    logic [7:0]             lo_next;
    logic [7:0]             hi_next;

    // ---------------- configuration port ----------------
    assign cfg_ready = 1'b1;
    assign cfg_sel   = mtc_qf_pkg::cfg_reg_t'(cfg_index);

    always_comb
    begin
        start_next  = start_reg;
        start_write = cfg_valid && (cfg_sel inside {mtc_qf_pkg::REG_START_HOURS,
                                                    mtc_qf_pkg::REG_START_MINUTES,
                                                    mtc_qf_pkg::REG_START_SECONDS,
                                                    mtc_qf_pkg::REG_START_FRAMES});
        if (cfg_valid)
        begin
            unique case (cfg_sel)
                mtc_qf_pkg::REG_START_HOURS:   start_next.hours   = cfg_data[4:0];
                mtc_qf_pkg::REG_START_MINUTES: start_next.minutes = cfg_data[5:0];
                mtc_qf_pkg::REG_START_SECONDS: start_next.seconds = cfg_data[5:0];
                mtc_qf_pkg::REG_START_FRAMES:  start_next.frames  = cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_thirty_reg   <= 1'b0;
            output_enable_reg <= 1'b0;
            start_reg         <= '0;
        end
        else
        begin
            start_reg <= start_next;
            if (cfg_valid && cfg_sel == mtc_qf_pkg::REG_RATE_THIRTY)
            begin
                rate_thirty_reg <= cfg_data[0];
            end
            if (cfg_valid && cfg_sel == mtc_qf_pkg::REG_OUTPUT_ENABLE)
            begin
                output_enable_reg <= cfg_data[0];
            end
        end
    end

    // ---------------- input register ----------------
    assign out_fire  = msg_valid_reg && out_ready;
    assign msg_free  = !msg_valid_reg || (out_ready && last_of_tick);
    // an idle tick leaves at once; a counting tick waits for the message register
    assign item_take = item_valid_reg && (!item_count_reg || msg_free);
    assign in_ready  = !item_valid_reg || item_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_count_reg <= count_enable;
        end
    end

    // ---------------- time counter ----------------
    always_comb
    begin
        tc_ctrl.load  = start_write;
        tc_ctrl.tick  = item_take;
        tc_ctrl.count = item_count_reg;
    end

    mtc_qf_timecode u_timecode (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (tc_ctrl),
        .start       (start_next),
        .rate_thirty (rate_thirty_reg),
        .step_time   (step_time),
        .step_piece  (step_piece)
    );

    // ---------------- message build ----------------
    always_comb
    begin
        case (step_piece)
            mtc_qf_pkg::PIECE_FRAMES:  unit_val = {1'b0, step_time.frames};
            mtc_qf_pkg::PIECE_SECONDS: unit_val = step_time.seconds;
            mtc_qf_pkg::PIECE_MINUTES: unit_val = step_time.minutes;
            default:                   unit_val = {1'b0, step_time.hours};
        endcase
        lo_next = {1'b0, step_piece, 1'b0, unit_val[3:0]};
        hi_next = {1'b0, step_piece, 1'b1, 2'b00, unit_val[5:4]};
        if (step_piece == mtc_qf_pkg::PIECE_HOURS)
        begin
            hi_next = hi_next | mtc_qf_pkg::HOURS_HIGH_TAG |
                      {4'h0, rate_thirty_reg ? mtc_qf_pkg::RATE_CODE_30
                                             : mtc_qf_pkg::RATE_CODE_25};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_valid_reg <= 1'b0;
            beat_reg      <= mtc_qf_pkg::BEAT_STATUS_LO;
        end
        else if (item_take && item_count_reg)
        begin
            msg_valid_reg <= 1'b1;
            beat_reg      <= mtc_qf_pkg::BEAT_STATUS_LO;
        end
        else if (out_fire && last_of_tick)
        begin
            msg_valid_reg <= 1'b0;
            beat_reg      <= mtc_qf_pkg::BEAT_STATUS_LO;
        end
        else if (out_fire)
        begin
            beat_reg <= beat_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take && item_count_reg)
        begin
            msg_bytes_reg <= output_enable_reg;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            msg_time_reg  <= step_time;
        end
    end

    // ---------------- result port ----------------
    always_comb
    begin
        out_valid    = msg_valid_reg;
        byte_valid   = msg_bytes_reg;
        last_of_tick = !msg_bytes_reg || (beat_reg == mtc_qf_pkg::BEAT_HI);
        time_hours   = msg_time_reg.hours;
        time_minutes = msg_time_reg.minutes;
        time_seconds = msg_time_reg.seconds;
        time_frames  = msg_time_reg.frames;
        if (!msg_bytes_reg)
        begin
            out_byte = 8'h00;
        end
        else
        begin
            case (beat_reg)
                mtc_qf_pkg::BEAT_STATUS_LO: out_byte = mtc_qf_pkg::QF_STATUS;
                mtc_qf_pkg::BEAT_LO:        out_byte = lo_reg;
                mtc_qf_pkg::BEAT_STATUS_HI: out_byte = mtc_qf_pkg::QF_STATUS;
                default:                    out_byte = hi_reg;
            endcase
        end
    end

    // ---------------- assertions ----------------
    a_status_single_beat : assert property (@(posedge clk) disable iff (!rst_n)
        (msg_valid_reg && !msg_bytes_reg) |-> (beat_reg == mtc_qf_pkg::BEAT_STATUS_LO))
        else $error("status result away from the first beat");

    a_new_msg_starts : assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && item_count_reg) |=>
        (msg_valid_reg && beat_reg == mtc_qf_pkg::BEAT_STATUS_LO))
        else $error("counting tick did not open a message at its first beat");

    a_drain_empties : assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && last_of_tick && !(item_take && item_count_reg)) |=> !msg_valid_reg)
        else $error("message register still full after its last beat");

    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && item_count_reg && msg_valid_reg) |-> (out_fire && last_of_tick))
        else $error("message overwritten before it was delivered");

endmodule

`default_nettype wire

@@ dv/midi_timecode_quarter_frame_gen_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midi_timecode_quarter_frame_gen_test
// Self-checking bench for the quarter-frame generator. Field ticks go in over
// a valid/ready channel and the bench keeps its own copy of the time counter,
// field flag and piece counter. From that copy it predicts every status
// result or quarter-frame byte and compares each output transaction with the
// oldest prediction. Directed runs cover the wrap points, the out-of-range
// start values and the spare register slots. Random phases then reprogram the
// block between bursts of ticks while the sender and the receiver idle and
// stall at random.
// ----------------------------------------------------------------------------

module midi_timecode_quarter_frame_gen_test;

    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned LONG_HOLD      = 80;
    localparam int unsigned RANDOM_TICKS   = 360;

    // Register slots that decode to nothing
    localparam logic [mtc_qf_pkg::CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [mtc_qf_pkg::CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_SPARSE,
        RX_RHYTHM
    } rx_pattern_t;

    typedef struct packed {
        logic [7:0]           msg_byte;
        logic                 is_msg;
        logic                 last;
        mtc_qf_pkg::tc_time_t tc;
    } qf_result_t;

    logic                               clk          = 1'b0;
    logic                               rst_n        = 1'b0;
    logic                               in_valid     = 1'b0;
    logic                               in_ready;
    logic                               count_enable = 1'b0;
    logic                               out_valid;
    logic                               out_ready    = 1'b0;
    logic [7:0]                         out_byte;
    logic                               byte_valid;
    logic                               last_of_tick;
    logic [4:0]                         time_hours;
    logic [5:0]                         time_minutes;
    logic [5:0]                         time_seconds;
    logic [4:0]                         time_frames;
    logic                               cfg_valid    = 1'b0;
    logic                               cfg_ready;
    logic [mtc_qf_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [mtc_qf_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;

    // Predicted state of the generator
    logic                 gen_rate_thirty = 1'b0;
    logic                 gen_out_enable  = 1'b0;
    mtc_qf_pkg::tc_time_t gen_start       = '0;
    mtc_qf_pkg::tc_time_t gen_time        = '0;
    logic                 gen_field       = 1'b1;
    logic [1:0]           gen_piece       = 2'd0;

    qf_result_t  qf_expected[$];
    int unsigned errors       = 0;
    int unsigned quiet_cycles = 0;

    bit          gaps_on    = 1'b1;
    int unsigned burst_left = 0;

    rx_pattern_t rx_pattern      = RX_FREE;
    int unsigned rx_pattern_left = 0;
    int unsigned rx_cycle        = 0;
    int unsigned hold_requests   = 0;
    int unsigned holds_served    = 0;
    int unsigned hold_left       = 0;

    always #2 clk = ~clk;

    midi_timecode_quarter_frame_gen DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .count_enable (count_enable),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .last_of_tick (last_of_tick),
        .time_hours   (time_hours),
        .time_minutes (time_minutes),
        .time_seconds (time_seconds),
        .time_frames  (time_frames),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic mtc_qf_pkg::tc_time_t next_frame(input mtc_qf_pkg::tc_time_t t,
                                                        input logic thirty);
        mtc_qf_pkg::tc_time_t n;
        logic [5:0] f;
        logic [6:0] s;
        logic [6:0] m;
        logic [5:0] h;
        n = t;
        f = {1'b0, t.frames} + 6'd1;
        // Compare at or above the limit so out-of-range values wrap too
        if (f >= (thirty ? mtc_qf_pkg::FRAMES_30_WRAP : mtc_qf_pkg::FRAMES_25_WRAP))
        begin
            n.frames = '0;
            s = {1'b0, t.seconds} + 7'd1;
            if (s >= mtc_qf_pkg::SECONDS_WRAP)
            begin
                n.seconds = '0;
                m = {1'b0, t.minutes} + 7'd1;
                if (m >= mtc_qf_pkg::MINUTES_WRAP)
                begin
                    n.minutes = '0;
                    h = {1'b0, t.hours} + 6'd1;
                    n.hours = (h >= mtc_qf_pkg::HOURS_WRAP) ? 5'd0 : h[4:0];
                end
                else
                    n.minutes = m[5:0];
            end
            else
                n.seconds = s[5:0];
        end
        else
            n.frames = f[4:0];
        return n;
    endfunction

    function automatic void push_result(input logic [7:0] b, input logic is_msg,
                                        input logic last);
        qf_result_t r;
        r.msg_byte = b;
        r.is_msg   = is_msg;
        r.last     = last;
        r.tc       = gen_time;
        qf_expected.push_back(r);
    endfunction

    function automatic void predict_tick(input logic counting);
        logic [5:0] unit;
        logic [7:0] lo_byte;
        logic [7:0] hi_byte;
        gen_field = ~gen_field;
        if (counting)
        begin
            if (!gen_field)
                gen_time = next_frame(gen_time, gen_rate_thirty);
            gen_piece = gen_piece + 2'd1;
            if (!gen_out_enable)
                push_result(8'h00, 1'b0, 1'b1);
            else
            begin
                case (gen_piece)
                    mtc_qf_pkg::PIECE_FRAMES:  unit = {1'b0, gen_time.frames};
                    mtc_qf_pkg::PIECE_SECONDS: unit = gen_time.seconds;
                    mtc_qf_pkg::PIECE_MINUTES: unit = gen_time.minutes;
                    default:                   unit = {1'b0, gen_time.hours};
                endcase
                lo_byte = {1'b0, gen_piece, 1'b0, unit[3:0]};
                hi_byte = {1'b0, gen_piece, 1'b1, 2'b00, unit[5:4]};
                if (gen_piece == mtc_qf_pkg::PIECE_HOURS)
                    hi_byte = hi_byte | mtc_qf_pkg::HOURS_HIGH_TAG
                            | {4'h0, (gen_rate_thirty ? mtc_qf_pkg::RATE_CODE_30
                                                      : mtc_qf_pkg::RATE_CODE_25)};
                push_result(mtc_qf_pkg::QF_STATUS, 1'b1, 1'b0);
                push_result(lo_byte, 1'b1, 1'b0);
                push_result(mtc_qf_pkg::QF_STATUS, 1'b1, 1'b0);
                push_result(hi_byte, 1'b1, 1'b1);
            end
        end
    endfunction

    function automatic void apply_register(input logic [mtc_qf_pkg::CFG_INDEX_W-1:0] idx,
                                           input logic [mtc_qf_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            mtc_qf_pkg::REG_RATE_THIRTY:   gen_rate_thirty   = data[0];
            mtc_qf_pkg::REG_OUTPUT_ENABLE: gen_out_enable    = data[0];
            mtc_qf_pkg::REG_START_HOURS:   gen_start.hours   = data[4:0];
            mtc_qf_pkg::REG_START_MINUTES: gen_start.minutes = data[5:0];
            mtc_qf_pkg::REG_START_SECONDS: gen_start.seconds = data[5:0];
            mtc_qf_pkg::REG_START_FRAMES:  gen_start.frames  = data[4:0];
            default: ;
        endcase
        // Any start write reloads the whole time and restarts the sequence
        if (idx == mtc_qf_pkg::REG_START_HOURS || idx == mtc_qf_pkg::REG_START_MINUTES ||
            idx == mtc_qf_pkg::REG_START_SECONDS || idx == mtc_qf_pkg::REG_START_FRAMES)
        begin
            gen_time  = gen_start;
            gen_piece = 2'd0;
            gen_field = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    task automatic send_tick(input logic counting);
        in_valid     <= 1'b1;
        count_enable <= counting;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_tick(counting);
        if (burst_left != 0)
            burst_left--;
        else if (gaps_on)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    // Leaves cfg_valid high so that writes can follow back to back
    task automatic write_register(input logic [mtc_qf_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [mtc_qf_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_register(idx, data);
    endtask

    task automatic end_config();
        cfg_valid <= 1'b0;
    endtask

    // Hold the sender until every predicted result is out, then let any
    // idle tick still inside the block drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (qf_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker, watchdog
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        rx_cycle++;
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served++;
            hold_left = LONG_HOLD - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            if (rx_pattern_left == 0)
            begin
                rx_pattern      = rx_pattern_t'($urandom_range(0, 3));
                rx_pattern_left = $urandom_range(16, 160);
            end
            else
                rx_pattern_left--;
            case (rx_pattern)
                RX_FREE:   out_ready <= 1'b1;
                RX_RANDOM: out_ready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:   out_ready <= (rx_cycle % 3 == 0);
            endcase
        end
    end

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        qf_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (qf_expected.size() == 0)
            begin
                $error("result with nothing expected: out_byte %0d byte_valid %0b",
                       out_byte, byte_valid);
                errors++;
            end
            else
            begin
                want = qf_expected.pop_front();
                compare_field("out_byte", want.msg_byte, out_byte);
                compare_field("byte_valid", {7'd0, want.is_msg}, {7'd0, byte_valid});
                compare_field("last_of_tick", {7'd0, want.last}, {7'd0, last_of_tick});
                compare_field("time_hours", {3'd0, want.tc.hours}, {3'd0, time_hours});
                compare_field("time_minutes", {2'd0, want.tc.minutes},
                              {2'd0, time_minutes});
                compare_field("time_seconds", {2'd0, want.tc.seconds},
                              {2'd0, time_seconds});
                compare_field("time_frames", {3'd0, want.tc.frames}, {3'd0, time_frames});
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else if (quiet_cycles < WATCHDOG_LIMIT)
            quiet_cycles++;
        else
        begin
            $error("no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: 25 fps, output off, so counting ticks give status only
    task automatic test_reset_defaults();
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        wait_idle();
    endtask

    // Full rollover at 30 fps, walking every piece including the hours tag
    task automatic test_wrap_thirty();
        write_register(mtc_qf_pkg::REG_RATE_THIRTY, 8'hFF);
        write_register(mtc_qf_pkg::REG_OUTPUT_ENABLE, 8'h01);
        write_register(mtc_qf_pkg::REG_START_HOURS, 8'd23);
        write_register(mtc_qf_pkg::REG_START_MINUTES, 8'd59);
        write_register(mtc_qf_pkg::REG_START_SECONDS, 8'd59);
        write_register(mtc_qf_pkg::REG_START_FRAMES, 8'd29);
        end_config();
        repeat (8)
            send_tick(1'b1);
        wait_idle();
    endtask

    // Rate write alone keeps the time; the frames write reloads it
    task automatic test_wrap_twenty_five();
        write_register(mtc_qf_pkg::REG_RATE_THIRTY, 8'hFE);
        write_register(mtc_qf_pkg::REG_START_FRAMES, 8'd24);
        end_config();
        repeat (4)
            send_tick(1'b1);
        wait_idle();
    endtask

    // All-ones writes land as out-of-range start values and must wrap
    task automatic test_out_of_range_start();
        write_register(mtc_qf_pkg::REG_START_HOURS, 8'hFF);
        write_register(mtc_qf_pkg::REG_START_MINUTES, 8'hFF);
        write_register(mtc_qf_pkg::REG_START_SECONDS, 8'hFF);
        write_register(mtc_qf_pkg::REG_START_FRAMES, 8'hFF);
        end_config();
        repeat (4)
            send_tick(1'b1);
        wait_idle();
    endtask

    task automatic test_spare_registers();
        write_register(REG_SPARE_6, 8'hFF);
        write_register(REG_SPARE_7, 8'h55);
        write_register(mtc_qf_pkg::REG_OUTPUT_ENABLE, 8'hFE);
        end_config();
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        wait_idle();
    endtask

    // Hold the receiver off while ticks keep coming, so the input stalls
    task automatic test_backpressure();
        write_register(mtc_qf_pkg::REG_OUTPUT_ENABLE, 8'h01);
        end_config();
        hold_requests++;
        while (holds_served != hold_requests)
            @(posedge clk);
        gaps_on = 1'b0;
        repeat (16)
            send_tick(1'b1);
        gaps_on = 1'b1;
        wait_idle();
    endtask

    task automatic program_random_phase();
        logic       thirty;
        logic [7:0] junk;
        logic [7:0] h;
        logic [7:0] m;
        logic [7:0] s;
        logic [7:0] f;
        thirty = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 2))
            0:
            begin
                h = 8'($urandom_range(0, 23));
                m = 8'($urandom_range(0, 59));
                s = 8'($urandom_range(0, 59));
                f = 8'($urandom_range(0, thirty ? 29 : 24));
            end
            1:
            begin
                h = 8'd23;
                m = 8'd59;
                s = 8'd59;
                f = (thirty ? 8'd29 : 8'd24) - 8'($urandom_range(0, 3));
            end
            default:
            begin
                // Raw bytes: upper bits are dropped, the rest may be out of range
                h = 8'($urandom);
                m = 8'($urandom);
                s = 8'($urandom);
                f = 8'($urandom);
            end
        endcase
        junk = 8'($urandom);
        write_register(mtc_qf_pkg::REG_RATE_THIRTY, {junk[7:1], thirty});
        junk = 8'($urandom);
        write_register(mtc_qf_pkg::REG_OUTPUT_ENABLE,
                       {junk[7:1], ($urandom_range(0, 3) != 0)});
        if ($urandom_range(0, 3) != 0)
            write_register(mtc_qf_pkg::REG_START_HOURS, h);
        if ($urandom_range(0, 3) != 0)
            write_register(mtc_qf_pkg::REG_START_MINUTES, m);
        if ($urandom_range(0, 3) != 0)
            write_register(mtc_qf_pkg::REG_START_SECONDS, s);
        if ($urandom_range(0, 3) != 0)
            write_register(mtc_qf_pkg::REG_START_FRAMES, f);
        if ($urandom_range(0, 7) == 0)
            write_register($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, 8'($urandom));
        end_config();
    endtask

    task automatic test_random_ticks();
        int unsigned sent;
        int unsigned phase_len;
        sent = 0;
        while (sent < RANDOM_TICKS)
        begin
            program_random_phase();
            gaps_on   = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(20, 50);
            repeat (phase_len)
                send_tick($urandom_range(0, 6) != 0);
            sent += phase_len;
            wait_idle();
        end
    endtask

    initial
    begin
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_wrap_thirty();
        test_wrap_twenty_five();
        test_out_of_range_start();
        test_spare_registers();
        test_backpressure();
        test_random_ticks();
        wait_idle();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (errors == 0 && qf_expected.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/mtc_qf_pkg.sv
rtl/core/mtc_qf_timecode.sv
rtl/core/midi_timecode_quarter_frame_gen.sv
dv/midi_timecode_quarter_frame_gen_test.sv
